/* design/bfs_pkg.sv */
// Shared types and constants for the bounded FIFO server with tail drop.
// No dependencies; every other file in this block imports it.
`timescale 1ns / 1ps

package bfs_pkg;

   localparam int TIME_W  = 48;
   localparam int INDEX_W = 16;
   localparam int LIMIT_W = 5;

   localparam logic [TIME_W-1:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   typedef struct packed {
      logic [31:0] arrival_time;
      logic [31:0] service_duration;
      logic        end_of_batch;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] request_index;
      logic [TIME_W-1:0]  finish_time;
      logic               rejected;
      logic               last_of_run;
   } rsp_type;

   // one waiting request as held in a queue cell
   typedef struct packed {
      logic [INDEX_W-1:0] request_index;
      logic [31:0]        arrival_time;
      logic [31:0]        service_duration;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WORK,
      ST_FINISH
   } state_type;

endpackage

/* design/bfs_cell.sv */
// One slot of the waiting queue, built as a shift chain toward the head.
// Depends on bfs_pkg for entry_type.
`timescale 1ns / 1ps

module bfs_cell
   import bfs_pkg::*;
(
   input  logic      clock,
   input  logic      shift,
   input  logic      load,
   input  entry_type upper,
   input  entry_type new_entry,
   output entry_type entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // load a new tail entry, or advance the neighbor's entry on a pop
   always_comb begin
      entry_in = entry_ff;
      if (load) begin
         entry_in = new_entry;
      end else if (shift) begin
         entry_in = upper;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

/* design/bfs_server.sv */
// Service time unit: start at the later of busy-until and arrival, add the
// duration, saturate at the largest time. Depends on bfs_pkg.
`timescale 1ns / 1ps

module bfs_server
   import bfs_pkg::*;
(
   input  logic [TIME_W-1:0] busy_until,
   input  logic [31:0]       arrival_time,
   input  logic [31:0]       service_duration,
   output logic [TIME_W-1:0] finish_time
);

   logic [TIME_W-1:0] arrival_ext;
   logic [TIME_W-1:0] start_time;
   logic [TIME_W:0]   sum;

   always_comb begin
      arrival_ext = TIME_W'(arrival_time);
      start_time  = (busy_until < arrival_ext) ? arrival_ext : busy_until;
      sum         = {1'b0, start_time} + (TIME_W + 1)'(service_duration);
      finish_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
   end

endmodule

/* design/bounded_fifo_server_with_tail_drop_unit.sv */
// Top level of the bounded FIFO server with tail drop; instantiates
// bfs_cell (queue chain) and bfs_server (finish time). Depends on bfs_pkg.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. Busy then stays high
// while the request is handled and while every waiting request that it
// releases (served before it, or drained at end of batch) is served, and no
// new request is taken until busy falls again, after those releases. The
// release loop runs through the one shared finish-time adder, one queued
// request per cycle. Results come out on rsp_data with a single-cycle rsp_valid
// strobe and cannot be held off, so the receiver must take each one when it
// appears; the final result of a request is on the ports in the first cycle
// with busy low. A request yields zero to QUEUE_DEPTH+1 results; the final one
// of each request carries last_of_run. The waiting queue is a chain of cells
// with the oldest request in cell zero; a pop moves every entry one cell toward
// the head. Write the queue limit through csr_ only while busy is low.

module bounded_fifo_server_with_tail_drop_unit
   import bfs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_data,
   output logic                rsp_valid,
   output rsp_type             rsp_data,
   input  logic                csr_write_enable,
   input  logic [LIMIT_W-1:0]  csr_write_data
);

   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W = 7;

   state_type state_ff, state_in;

   logic [LIMIT_W-1:0] queue_limit_ff, queue_limit_in;
   logic [31:0]        t_ff, t_in;
   logic [31:0]        d_ff, d_in;
   logic               last_ff, last_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [INDEX_W-1:0] next_index_ff, next_index_in;
   logic [TIME_W-1:0]  busy_until_ff, busy_until_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               pend_valid_ff, pend_valid_in;
   rsp_type            pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // control decoded from the state
   logic               accept;
   logic               do_pop;
   logic               do_push;
   logic               serve;
   logic               new_valid;
   rsp_type            new_rsp;
   logic               flush;
   logic               clear;

   logic               can_pop;
   logic               server_free;
   logic               room;
   logic [CMP_W-1:0]   limit;
   logic               drain_more;

   entry_type          cell_q [QUEUE_DEPTH];
   entry_type          head;
   entry_type          tail_entry;
   logic [31:0]        srv_arrival;
   logic [31:0]        srv_duration;
   logic [TIME_W-1:0]  finish;

   // ---------------------------------------------------------------
   // Queue chain: cell zero holds the oldest waiting request
   // ---------------------------------------------------------------
   assign tail_entry = '{request_index: idx_ff, arrival_time: t_ff,
                         service_duration: d_ff};

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type upper;
      if (i == QUEUE_DEPTH - 1) begin : g_end
         assign upper = cell_q[i];
      end else begin : g_mid
         assign upper = cell_q[i+1];
      end
      bfs_cell u_cell (
         .clock     (clock),
         .shift     (do_pop),
         .load      (do_push && (count_ff == CW'(i))),
         .upper     (upper),
         .new_entry (tail_entry),
         .entry     (cell_q[i])
      );
   end

   assign head = cell_q[0];

   // ---------------------------------------------------------------
   // Finish time: the head on a pop, otherwise the arriving request
   // ---------------------------------------------------------------
   assign srv_arrival  = do_pop ? head.arrival_time     : t_ff;
   assign srv_duration = do_pop ? head.service_duration : d_ff;

   bfs_server u_server (
      .busy_until       (busy_until_ff),
      .arrival_time     (srv_arrival),
      .service_duration (srv_duration),
      .finish_time      (finish)
   );

   // ---------------------------------------------------------------
   // Decisions
   // ---------------------------------------------------------------
   always_comb begin
      limit = (CMP_W'(queue_limit_ff) > CMP_W'(QUEUE_DEPTH)) ?
              CMP_W'(QUEUE_DEPTH) : CMP_W'(queue_limit_ff);
      server_free = busy_until_ff <= TIME_W'(t_ff);
      can_pop     = (count_ff != '0) && server_free;
      room        = CMP_W'(count_ff) < limit;
      drain_more  = last_ff && (count_ff != '0);
      accept      = start && (state_ff == ST_IDLE);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_WORK;
         end
         ST_WORK: begin
            if (!can_pop) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!drain_more) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      do_pop    = 1'b0;
      do_push   = 1'b0;
      serve     = 1'b0;
      new_valid = 1'b0;
      new_rsp   = '0;
      flush     = 1'b0;
      clear     = 1'b0;
      case (state_ff)
         ST_WORK: begin
            if (can_pop) begin
               // serve queued requests whose turn comes at or before this arrival
               do_pop    = 1'b1;
               serve     = 1'b1;
               new_valid = 1'b1;
               new_rsp.request_index = head.request_index;
               new_rsp.finish_time   = finish;
            end else if ((count_ff == '0) && server_free) begin
               serve     = 1'b1;
               new_valid = 1'b1;
               new_rsp.request_index = idx_ff;
               new_rsp.finish_time   = finish;
            end else if (room) begin
               do_push = 1'b1;
            end else begin
               // tail drop
               new_valid = 1'b1;
               new_rsp.request_index = idx_ff;
               new_rsp.rejected      = 1'b1;
            end
         end
         ST_FINISH: begin
            if (drain_more) begin
               do_pop    = 1'b1;
               serve     = 1'b1;
               new_valid = 1'b1;
               new_rsp.request_index = head.request_index;
               new_rsp.finish_time   = finish;
            end else begin
               flush = 1'b1;
               clear = last_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Register next values
   // ---------------------------------------------------------------
   always_comb begin
      queue_limit_in = csr_write_enable ? csr_write_data : queue_limit_ff;

      t_in    = accept ? req_data.arrival_time     : t_ff;
      d_in    = accept ? req_data.service_duration : d_ff;
      last_in = accept ? req_data.end_of_batch     : last_ff;
      idx_in  = accept ? next_index_ff             : idx_ff;

      next_index_in = next_index_ff;
      if (accept) next_index_in = next_index_ff + 1'b1;
      if (clear)  next_index_in = '0;

      busy_until_in = busy_until_ff;
      if (serve) busy_until_in = finish;
      if (clear) busy_until_in = '0;

      count_in = count_ff;
      if (do_pop)  count_in = count_ff - 1'b1;
      if (do_push) count_in = count_ff + 1'b1;

      // hold one result back so the final one of a request can be marked
      pend_in       = new_valid ? new_rsp : pend_ff;
      pend_valid_in = pend_valid_ff;
      if (flush)     pend_valid_in = 1'b0;
      if (new_valid) pend_valid_in = 1'b1;

      rsp_valid_in = pend_valid_ff && (new_valid || flush);
      rsp_data_in  = pend_ff;
      rsp_data_in.last_of_run = flush;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         queue_limit_ff <= LIMIT_RESET;
         next_index_ff  <= '0;
         busy_until_ff  <= '0;
         count_ff       <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         queue_limit_ff <= queue_limit_in;
         next_index_ff  <= next_index_in;
         busy_until_ff  <= busy_until_in;
         count_ff       <= count_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      t_ff        <= t_in;
      d_ff        <= d_in;
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(QUEUE_DEPTH))
      else $error("queue occupancy above depth");

   a_pop_push: assert property (@(posedge clock) disable iff (reset)
      !(do_pop && do_push))
      else $error("pop and push in the same cycle");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_of_run |-> state_ff == ST_IDLE)
      else $error("final result of a transaction while still busy");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) != ST_IDLE)
      else $error("result strobe without work in progress");

endmodule

/* bench/testbench.sv */
// Self-checking bench for bounded_fifo_server_with_tail_drop_unit: directed table and
// random batches, scored against an in-bench finish-time predictor or typed-in results.
// Depends on bfs_pkg and the design files under design/.
`timescale 1ns / 1ps

module testbench;
   import bfs_pkg::*;

   localparam int QUEUE_DEPTH   = 16;
   // Quiet margin after the last awaited result, padded well past the longest item.
   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_LIMIT   = 10000;

   typedef enum logic {
      STEP_ITEM,
      STEP_LIMIT
   } step_kind_type;

   // One row of the directed plan: either a request or a queue-limit write.
   // Where "typed" is set, "known" is the single result the row must give.
   typedef struct packed {
      step_kind_type      kind;
      req_type            item;
      logic [LIMIT_W-1:0] limit;
      logic               typed;
      rsp_type            known;
   } plan_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   req_type            req_data = '0;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               csr_write_enable = 1'b0;
   logic [LIMIT_W-1:0] csr_write_data = '0;

   // Predictor state: the waiting line, the time the server frees up, the next
   // request number and the queue limit as last written.
   entry_type          waiting_line[$];
   logic [TIME_W-1:0]  server_free_at = '0;
   logic [INDEX_W-1:0] issue_index = '0;
   logic [LIMIT_W-1:0] line_limit = LIMIT_RESET;

   // Results still to come out of the block, oldest first.
   rsp_type            awaited_results[$];
   rsp_type            held_result;
   bit                 holding = 1'b0;

   plan_row_type       plan[$];
   bit                 idling_on = 1'b1;
   int                 fault_count = 0;
   rsp_type            due;

   bounded_fifo_server_with_tail_drop_unit #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      #10 clock = ~clock;
   end

   // Hard stop in case the block hangs or drops a result.
   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic logic [TIME_W-1:0] finish_at(input logic [TIME_W-1:0] begin_at,
                                                  input logic [31:0] duration);
      logic [TIME_W:0] total;
      total = {1'b0, begin_at} + {{(TIME_W-31){1'b0}}, duration};
      // Clamp at the top of the time range instead of wrapping.
      return total[TIME_W] ? TIME_MAX : total[TIME_W-1:0];
   endfunction

   // Hold back the newest result so the last one of a transaction can be marked.
   task automatic post_finish(input logic [INDEX_W-1:0] index,
                              input logic [TIME_W-1:0] finish, input logic refused);
      if (holding)
         awaited_results.push_back(held_result);
      held_result.request_index = index;
      held_result.finish_time   = finish;
      held_result.rejected      = refused;
      held_result.last_of_run   = 1'b0;
      holding = 1'b1;
   endtask

   // Serve the oldest waiting request; it starts no earlier than its own arrival.
   task automatic release_head();
      entry_type         head;
      logic [TIME_W-1:0] begin_at;
      head = waiting_line.pop_front();
      begin_at = server_free_at;
      if (begin_at < {16'h0, head.arrival_time})
         begin_at = {16'h0, head.arrival_time};
      server_free_at = finish_at(begin_at, head.service_duration);
      post_finish(head.request_index, server_free_at, 1'b0);
   endtask

   task automatic schedule_request(input req_type r);
      logic [INDEX_W-1:0] index;
      logic [TIME_W-1:0]  arrive;
      int                 cap;
      entry_type          slot;
      index = issue_index;
      issue_index = issue_index + 1'b1;
      arrive = {16'h0, r.arrival_time};
      // A queue limit above the physical depth acts as the depth.
      cap = (line_limit > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(line_limit);

      // Clear out everyone whose turn comes at or before this arrival.
      while (waiting_line.size() > 0 && server_free_at <= arrive)
         release_head();

      if (waiting_line.size() == 0 && server_free_at <= arrive) begin
         server_free_at = finish_at(arrive, r.service_duration);
         post_finish(index, server_free_at, 1'b0);
      end else if (waiting_line.size() < cap) begin
         slot.request_index    = index;
         slot.arrival_time     = r.arrival_time;
         slot.service_duration = r.service_duration;
         waiting_line.push_back(slot);
      end else begin
         // Tail drop: the line is full.
         post_finish(index, '0, 1'b1);
      end

      if (r.end_of_batch) begin
         while (waiting_line.size() > 0)
            release_head();
         server_free_at = '0;
         issue_index = '0;
      end

      if (holding) begin
         held_result.last_of_run = 1'b1;
         awaited_results.push_back(held_result);
         holding = 1'b0;
      end
   endtask

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Present one request and hold it until the block takes it. Where a result
   // is typed in, replace what the predictor posted for this transaction.
   task automatic send_item(input req_type item, input logic typed, input rsp_type known);
      int      gap;
      int      mark;
      rsp_type dropped;
      gap = 0;
      if (idling_on && $urandom_range(99) < 37)
         gap = $urandom_range(1, 5);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      do
         @(posedge clock);
      while (busy);
      mark = awaited_results.size();
      schedule_request(item);
      if (typed) begin
         while (awaited_results.size() > mark)
            dropped = awaited_results.pop_back();
         awaited_results.push_back(known);
      end
   endtask

   // Drop start, wait for every awaited result, then let the block go quiet:
   // an item that only queues gives no result yet may still be in flight.
   task automatic settle();
      int n;
      start <= 1'b0;
      for (n = 0; n < DRAIN_LIMIT && awaited_results.size() > 0; n++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_line_limit(input logic [LIMIT_W-1:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      line_limit = value;
   endtask

   task automatic add_item(input logic [31:0] arrival, input logic [31:0] duration,
                           input logic last);
      plan_row_type row;
      row = '0;
      row.kind = STEP_ITEM;
      row.item.arrival_time = arrival;
      row.item.service_duration = duration;
      row.item.end_of_batch = last;
      plan.push_back(row);
   endtask

   // Same as add_item, plus the one result the row must produce.
   task automatic add_checked(input logic [31:0] arrival, input logic [31:0] duration,
                              input logic last, input logic [INDEX_W-1:0] index,
                              input logic [TIME_W-1:0] finish, input logic refused);
      plan_row_type row;
      row = '0;
      row.kind = STEP_ITEM;
      row.item.arrival_time = arrival;
      row.item.service_duration = duration;
      row.item.end_of_batch = last;
      row.typed = 1'b1;
      row.known.request_index = index;
      row.known.finish_time = finish;
      row.known.rejected = refused;
      row.known.last_of_run = 1'b1;
      plan.push_back(row);
   endtask

   task automatic add_limit(input logic [LIMIT_W-1:0] value);
      plan_row_type row;
      row = '0;
      row.kind = STEP_LIMIT;
      row.limit = value;
      plan.push_back(row);
   endtask

   // Random batches: mostly non-decreasing arrivals with random content, some
   // congested so the line fills and drops, a few out-of-order jumps and huge
   // durations as noise. Every batch ends with end_of_batch.
   task automatic run_batches(input int items);
      int          sent;
      int          len;
      int          k;
      bit          congested;
      logic [31:0] arrival;
      logic [32:0] stride;
      req_type     item;
      sent = 0;
      while (sent < items) begin
         len = $urandom_range(1, 24);
         if (len > items - sent)
            len = items - sent;
         congested = ($urandom_range(2) == 0);
         case ($urandom_range(5))
            0: begin
               arrival = $urandom;
            end
            1: begin
               arrival = 32'hFFFF_FFFF - $urandom_range(0, 40);
            end
            default: begin
               arrival = $urandom_range(0, 1000);
            end
         endcase
         for (k = 0; k < len; k++) begin
            if ($urandom_range(11) == 0) begin
               arrival = $urandom;
            end else if (k > 0) begin
               stride = {1'b0, arrival} + $urandom_range(0, congested ? 3 : 30);
               arrival = stride[32] ? 32'hFFFF_FFFF : stride[31:0];
            end
            item.arrival_time = arrival;
            if (congested && k == 0)
               item.service_duration = $urandom_range(300, 3000);
            else if ($urandom_range(29) == 0)
               item.service_duration = $urandom;
            else
               item.service_duration = $urandom_range(0, 25);
            item.end_of_batch = (k == len - 1);
            send_item(item, 1'b0, '0);
         end
         sent += len;
      end
   endtask

   // ---------------------------------------------------------------------
   // Result checker: every strobe must match the oldest awaited result.
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result: index %0d finish %0d rejected %0b last %0b",
                     $time, rsp_data.request_index, rsp_data.finish_time,
                     rsp_data.rejected, rsp_data.last_of_run);
            fault_count++;
         end else begin
            due = awaited_results.pop_front();
            if (rsp_data.request_index !== due.request_index) begin
               $display("%0t: request_index expected %0d actual %0d", $time,
                        due.request_index, rsp_data.request_index);
               fault_count++;
            end
            if (rsp_data.finish_time !== due.finish_time) begin
               $display("%0t: finish_time expected %0d actual %0d (index %0d)", $time,
                        due.finish_time, rsp_data.finish_time, due.request_index);
               fault_count++;
            end
            if (rsp_data.rejected !== due.rejected) begin
               $display("%0t: rejected expected %0b actual %0b (index %0d)", $time,
                        due.rejected, rsp_data.rejected, due.request_index);
               fault_count++;
            end
            if (rsp_data.last_of_run !== due.last_of_run) begin
               $display("%0t: last_of_run expected %0b actual %0b (index %0d)", $time,
                        due.last_of_run, rsp_data.last_of_run, due.request_index);
               fault_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin
      int i;

      // Reset state, limit sixteen: plain service, queuing, release on arrival
      // including a finish exactly at the arrival time, and an end of batch that finds the line empty.
      add_checked(32'd0, 32'd5, 1'b0, 16'd0, 48'd5, 1'b0);
      add_item(32'd0, 32'd10, 1'b0);
      add_item(32'd2, 32'd1, 1'b0);
      add_item(32'd5, 32'd3, 1'b0);
      add_item(32'd16, 32'd0, 1'b0);
      add_item(32'd30, 32'd7, 1'b1);
      // Largest arrival and duration, then the same again drained at end of batch.
      add_checked(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'd0, 48'h1_FFFF_FFFE, 1'b0);
      add_checked(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'd1, 48'h2_FFFF_FFFD, 1'b0);
      // Limit zero: nobody may wait, so a busy server means a drop.
      add_limit(5'd0);
      add_checked(32'd10, 32'd100, 1'b0, 16'd0, 48'd110, 1'b0);
      add_checked(32'd20, 32'd1, 1'b0, 16'd1, 48'd0, 1'b1);
      add_checked(32'd110, 32'd0, 1'b1, 16'd2, 48'd110, 1'b0);
      // Limit two: fill the line, drop the third, then release a burst and
      // finish with an arrival earlier than the busy time.
      add_limit(5'd2);
      add_checked(32'd0, 32'd50, 1'b0, 16'd0, 48'd50, 1'b0);
      add_item(32'd1, 32'd1, 1'b0);
      add_item(32'd2, 32'd1, 1'b0);
      add_checked(32'd3, 32'd1, 1'b0, 16'd3, 48'd0, 1'b1);
      add_item(32'd60, 32'hFFFF_FFFF, 1'b0);
      add_item(32'd0, 32'd0, 1'b1);
      // Limit above the physical depth, all five bits set.
      add_limit(5'd31);
      add_checked(32'd0, 32'd0, 1'b1, 16'd0, 48'd0, 1'b0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed plan.
      for (i = 0; i < plan.size(); i++) begin
         if (plan[i].kind == STEP_LIMIT)
            set_line_limit(plan[i].limit);
         else
            send_item(plan[i].item, plan[i].typed, plan[i].known);
      end

      // Random phases across several limits; one phase runs without idling.
      run_batches(16);
      set_line_limit(5'd1);
      run_batches(15);
      set_line_limit(5'd0);
      run_batches(12);
      set_line_limit(5'd16);
      idling_on = 1'b0;
      run_batches(16);
      idling_on = 1'b1;
      set_line_limit(LIMIT_W'($urandom_range(2, 15)));
      run_batches(16);
      set_line_limit(LIMIT_W'($urandom_range(17, 31)));
      run_batches(17);

      settle();
      if (awaited_results.size() > 0) begin
         $display("%0t: %0d results never arrived, oldest index %0d", $time,
                  awaited_results.size(), awaited_results[0].request_index);
         fault_count++;
      end

      if (fault_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
